FILE: hw/rtl/tlpt_pkg.sv
package tlpt_pkg;

  // Commands carried in a request transaction; the fourth code is ignored.
  typedef enum logic [1:0] {
    CMD_TRANSLATE = 2'd0,
    CMD_MAP       = 2'd1,
    CMD_UNMAP     = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_FRAME = 2'd1,
    STAT_PRESENT  = 2'd2
  } status_e;

  // Entry format: bit 0 present, bit 1 read-write, bit 2 user, 31..12 frame.
  localparam logic [31:0] BIT_PRESENT = 32'h0000_0001;
  localparam logic [31:0] BIT_RW      = 32'h0000_0002;
  localparam logic [31:0] BIT_USER    = 32'h0000_0004;
  localparam logic [31:0] LOW_MASK    = 32'h0000_0FFF;
  localparam logic [31:0] FRAME_MASK  = ~LOW_MASK;
  localparam logic [9:0]  INDEX_MASK  = 10'h3FF;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [11:0] page_flags;
    logic [31:0] table_frame;
  } req_t;

  typedef struct packed {
    logic [31:0] phys_result;
    logic [1:0]  status;
    logic        table_frame_used;
    logic        table_released;
    logic [31:0] released_frame;
  } rsp_t;

endpackage

FILE: hw/rtl/tlpt_index.sv
module tlpt_index import tlpt_pkg::*; #(
  parameter int DIR_ENTRIES   = 1024,
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic [31:0]                                    virt_addr_i,
  output logic [$clog2(DIR_ENTRIES)-1:0]                 dir_idx_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0]               tbl_idx_o,
  output logic [$clog2(DIR_ENTRIES*TABLE_ENTRIES)-1:0]   tbl_base_o
);

  localparam int DW = $clog2(DIR_ENTRIES);
  localparam int TW = $clog2(TABLE_ENTRIES);
  localparam int AW = $clog2(DIR_ENTRIES*TABLE_ENTRIES);

  // Reduce a 10-bit index modulo M (M >= 16, so the quotient stays below 64):
  // six conditional subtracts of shifted copies of M.
  function automatic logic [15:0] reduce(input logic [9:0] v, input logic [15:0] m);
    logic [15:0] r;
    r = {6'd0, v};
    for (int k = 5; k >= 0; k--) begin
      if (r >= (m << k)) begin
        r = r - (m << k);
      end
    end
    return r;
  endfunction

  logic [15:0] dir_red;
  logic [15:0] tbl_red;

  assign dir_red   = reduce(virt_addr_i[31:22] & INDEX_MASK, 16'(DIR_ENTRIES));
  assign tbl_red   = reduce(virt_addr_i[21:12] & INDEX_MASK, 16'(TABLE_ENTRIES));
  assign dir_idx_o = dir_red[DW-1:0];
  assign tbl_idx_o = tbl_red[TW-1:0];
  assign tbl_base_o = AW'(dir_red[DW-1:0]) * AW'(TABLE_ENTRIES);

endmodule

FILE: hw/rtl/two_level_page_table_manager.sv
// Two-level page table manager with a 10/10/12 virtual address split. Issue a
// request transaction by raising start_i while busy_o is low; exactly one
// response transaction follows, shown on rsp_o for a single cycle while done_o
// is high, and the receiver must take it then since it cannot be held. The
// directory and the page tables live in two single-port-read, single-port-write
// synchronous memories with registered read data, so every request is a chain
// of dependent reads: translate with a present directory entry, and map into an
// existing table, pass from accept to response through the directory read, the
// table read and the result register. A request that finds its directory entry
// absent and creates no table, and an unknown command, go from the directory
// read straight to the result register. Map that creates a table clears its
// TABLE_ENTRIES words one per cycle. Unmap on a present table scans the table
// one word per cycle and stops at the first nonzero word. Requests are handled
// one at a time; a new one may be accepted in the cycle its predecessor's
// response is shown. After reset the block clears the directory, one entry per
// cycle, holding busy_o high until the last entry is written. Table memory is
// never cleared globally: each table is cleared when map creates it.
module two_level_page_table_manager import tlpt_pkg::*; #(
  parameter int DIR_ENTRIES   = 1024,
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int DW        = $clog2(DIR_ENTRIES);
  localparam int TW        = $clog2(TABLE_ENTRIES);
  localparam int TBL_DEPTH = DIR_ENTRIES * TABLE_ENTRIES;
  localparam int AW        = $clog2(TBL_DEPTH);
  localparam int MAXN      = (DIR_ENTRIES > TABLE_ENTRIES) ? DIR_ENTRIES : TABLE_ENTRIES;
  localparam int CW        = $clog2(MAXN + 1);

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_DIR  = 6'b000100,
    S_TBL  = 6'b001000,
    S_CLR  = 6'b010000,
    S_SCAN = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Request context, captured at accept.
  req_t            req_q;
  logic [DW-1:0]   di_q;
  logic [TW-1:0]   ti_q;
  logic [AW-1:0]   base_q;
  logic [31:0]     dent_q, dent_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            chk_vld_q, chk_vld_d;
  logic            chk_last_q, chk_last_d;

  logic            done_q, done_d;
  rsp_t            rsp_q, rsp_d;

  logic [DW-1:0]   idx_di;
  logic [TW-1:0]   idx_ti;
  logic [AW-1:0]   idx_base;
  logic            accept;

  // Memory ports.
  logic [31:0]     dir_mem [DIR_ENTRIES];
  logic            dir_re, dir_we;
  logic [DW-1:0]   dir_raddr, dir_waddr;
  logic [31:0]     dir_wdata, dir_rdata_q;

  logic [31:0]     tbl_mem [TBL_DEPTH];
  logic            tbl_re, tbl_we;
  logic [AW-1:0]   tbl_raddr, tbl_waddr;
  logic [31:0]     tbl_wdata, tbl_rdata_q;

  logic [AW-1:0]   taddr;
  logic [31:0]     new_pte;
  logic [31:0]     new_pde;

  tlpt_index #(
    .DIR_ENTRIES  (DIR_ENTRIES),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_index (
    .virt_addr_i(req_i.virt_addr),
    .dir_idx_o  (idx_di),
    .tbl_idx_o  (idx_ti),
    .tbl_base_o (idx_base)
  );

  assign busy_o  = (state_q != S_IDLE);
  assign accept  = start_i && !busy_o;
  assign done_o  = done_q;
  assign rsp_o   = rsp_q;
  assign taddr   = base_q + AW'(ti_q);
  assign new_pte = (req_q.phys_addr & FRAME_MASK) | {20'd0, req_q.page_flags} | BIT_PRESENT;
  assign new_pde = (req_q.table_frame & FRAME_MASK) | BIT_RW
                 | ({20'd0, req_q.page_flags} & BIT_USER) | BIT_PRESENT;

  // Memories: registered read data held between reads.
  always_ff @(posedge clk_i) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (dir_re) begin
      dir_rdata_q <= dir_mem[dir_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (tbl_re) begin
      tbl_rdata_q <= tbl_mem[tbl_raddr];
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    dent_d     = dent_q;
    chk_vld_d  = 1'b0;
    chk_last_d = 1'b0;
    done_d     = 1'b0;
    rsp_d      = '0;

    dir_re    = accept;
    dir_raddr = idx_di;
    dir_we    = 1'b0;
    dir_waddr = di_q;
    dir_wdata = '0;

    tbl_re    = 1'b0;
    tbl_raddr = taddr;
    tbl_we    = 1'b0;
    tbl_waddr = taddr;
    tbl_wdata = '0;

    case (state_q)
      S_INIT: begin
        // Clear the directory after reset, one entry per cycle.
        dir_we    = 1'b1;
        dir_waddr = cnt_q[DW-1:0];
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CW'(DIR_ENTRIES - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          state_d = S_DIR;
        end
      end

      S_DIR: begin
        dent_d = dir_rdata_q;
        if (req_q.command == CMD_TRANSLATE) begin
          if ((dir_rdata_q & BIT_PRESENT) != '0) begin
            tbl_re  = 1'b1;
            state_d = S_TBL;
          end else begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else if (req_q.command == CMD_MAP) begin
          if ((dir_rdata_q & BIT_PRESENT) != '0) begin
            tbl_re  = 1'b1;
            state_d = S_TBL;
          end else if (req_q.table_frame == '0) begin
            rsp_d.status = STAT_NO_FRAME;
            done_d       = 1'b1;
            state_d      = S_IDLE;
          end else begin
            // Create the table, then sweep it clear.
            dir_we    = 1'b1;
            dir_wdata = new_pde;
            cnt_d     = '0;
            state_d   = S_CLR;
          end
        end else if (req_q.command == CMD_UNMAP) begin
          if ((dir_rdata_q & BIT_PRESENT) != '0) begin
            tbl_we  = 1'b1;
            cnt_d   = '0;
            state_d = S_SCAN;
          end else begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_TBL: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (req_q.command == CMD_TRANSLATE) begin
          if ((tbl_rdata_q & BIT_PRESENT) != '0) begin
            rsp_d.phys_result = {tbl_rdata_q[31:12], req_q.virt_addr[11:0]};
          end
        end else if ((tbl_rdata_q & BIT_PRESENT) != '0) begin
          rsp_d.status = STAT_PRESENT;
        end else begin
          tbl_we    = 1'b1;
          tbl_wdata = new_pte;
        end
      end

      S_CLR: begin
        // Zero the new table; drop the new entry in at its own slot.
        tbl_we    = 1'b1;
        tbl_waddr = base_q + AW'(cnt_q[TW-1:0]);
        tbl_wdata = (cnt_q[TW-1:0] == ti_q) ? new_pte : '0;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CW'(TABLE_ENTRIES - 1)) begin
          rsp_d.table_frame_used = 1'b1;
          done_d                 = 1'b1;
          state_d                = S_IDLE;
        end
      end

      S_SCAN: begin
        // Stream reads over the table, checking each word in the cycle after its read.
        if (cnt_q < CW'(TABLE_ENTRIES)) begin
          tbl_re     = 1'b1;
          tbl_raddr  = base_q + AW'(cnt_q[TW-1:0]);
          cnt_d      = cnt_q + 1'b1;
          chk_vld_d  = 1'b1;
          chk_last_d = (cnt_q == CW'(TABLE_ENTRIES - 1));
        end
        if (chk_vld_q && (tbl_rdata_q != '0)) begin
          tbl_re  = 1'b0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (chk_vld_q && chk_last_q) begin
          dir_we                = 1'b1;
          rsp_d.table_released  = 1'b1;
          rsp_d.released_frame  = dent_q & FRAME_MASK;
          done_d                = 1'b1;
          state_d               = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      cnt_q      <= '0;
      chk_vld_q  <= 1'b0;
      chk_last_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      chk_vld_q  <= chk_vld_d;
      chk_last_q <= chk_last_d;
      done_q     <= done_d;
    end
  end

  // Payload and request context carry no reset.
  always_ff @(posedge clk_i) begin
    rsp_q  <= rsp_d;
    dent_q <= dent_d;
    if (accept) begin
      req_q  <= req_i;
      di_q   <= idx_di;
      ti_q   <= idx_ti;
      base_q <= idx_base;
    end
  end

  // A response strobe never lasts more than one cycle.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("response strobe held for two cycles");

  // An accepted request keeps the block busy until its response.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("request accepted without holding busy");

  // A released table never comes with a map outcome.
  a_release_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.table_released) |->
      (rsp_o.status == STAT_OK && !rsp_o.table_frame_used && rsp_o.phys_result == '0))
    else $error("release reported together with map or translate fields");

  // A refused map never yields a translation.
  a_status_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != STAT_OK) |-> (rsp_o.phys_result == '0))
    else $error("error status with nonzero translation");

endmodule

FILE: bench/two_level_page_table_manager_tb.sv
`timescale 1ns / 1ps

module two_level_page_table_manager_tb;
  import tlpt_pkg::*;

  localparam int DIR_ENTRIES   = 1024;
  localparam int TABLE_ENTRIES = 1024;
  // Slowest legal transaction is a full table clear or scan; allow for that on
  // every item, plus sender gaps, the clearing pass after reset, and a wide
  // margin on top.
  localparam int CYCLE_LIMIT   = 12_000_000;
  localparam int DRAIN_CYCLES  = 50;
  localparam int PHASE_ITEMS   = 488;
  localparam int DIR_POOL      = 4;
  localparam int TBL_POOL      = 8;
  // The fourth command code has no name in the package; the block ignores it.
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam rsp_t QUIET = '0;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;

  two_level_page_table_manager #(
    .DIR_ENTRIES  (DIR_ENTRIES),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Shadow copy of the page tables. Table words live in a sparse store;
  // a missing key reads as zero, which is what a freshly cleared table holds.
  logic [31:0] dir_words [DIR_ENTRIES];
  logic [31:0] page_words [int unsigned];

  // Responses owed by the block, oldest first.
  rsp_t pending_rsp [$];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned n_translate, n_hit, n_map, n_unmap, n_release, n_no_frame;
  int unsigned n_present, n_created, n_ignored;

  // Addresses for the random part come from small per-phase pools so that
  // maps collide, translations hit and unmaps really empty tables.
  logic [9:0] dir_pool [DIR_POOL];
  logic [9:0] tbl_pool [TBL_POOL];

  typedef struct {
    req_t req;
    bit   fixed;
    rsp_t want;
  } script_row_t;

  script_row_t script [$];

  function automatic logic [31:0] page_word(int unsigned idx);
    return page_words.exists(idx) ? page_words[idx] : 32'h0;
  endfunction

  // Advance the shadow tables by one request and return the response it owes.
  function automatic rsp_t walk_tables(input req_t r);
    int unsigned di, ti, base, k;
    logic [31:0] pte;
    bit ok, empty;
    rsp_t o;
    o = '0;
    di = int'(r.virt_addr[31:22]) % DIR_ENTRIES;
    ti = int'(r.virt_addr[21:12]) % TABLE_ENTRIES;
    base = di * TABLE_ENTRIES;
    case (r.command)
      CMD_TRANSLATE: begin
        if ((dir_words[di] & BIT_PRESENT) != 0) begin
          pte = page_word(base + ti);
          if ((pte & BIT_PRESENT) != 0)
            o.phys_result = (pte & FRAME_MASK) + (r.virt_addr & LOW_MASK);
        end
      end
      CMD_MAP: begin
        ok = 1'b1;
        if ((dir_words[di] & BIT_PRESENT) == 0) begin
          if (r.table_frame == 32'h0) begin
            o.status = STAT_NO_FRAME;
            ok = 1'b0;
          end else begin
            dir_words[di] = (r.table_frame & FRAME_MASK) | BIT_RW |
                            ({20'h0, r.page_flags} & BIT_USER) | BIT_PRESENT;
            for (k = 0; k < TABLE_ENTRIES; k++) page_words.delete(base + k);
            o.table_frame_used = 1'b1;
          end
        end
        if (ok) begin
          if ((page_word(base + ti) & BIT_PRESENT) != 0)
            o.status = STAT_PRESENT;
          else
            page_words[base + ti] = (r.phys_addr & FRAME_MASK) |
                                    {20'h0, r.page_flags} | BIT_PRESENT;
        end
      end
      CMD_UNMAP: begin
        if ((dir_words[di] & BIT_PRESENT) != 0) begin
          page_words.delete(base + ti);
          empty = 1'b1;
          for (k = 0; k < TABLE_ENTRIES && empty; k++)
            if (page_word(base + k) != 32'h0) empty = 1'b0;
          if (empty) begin
            o.released_frame = dir_words[di] & FRAME_MASK;
            o.table_released = 1'b1;
            dir_words[di] = 32'h0;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic script_row_t script_row(input logic [1:0] c, input logic [31:0] va,
                                             input logic [31:0] pa, input logic [11:0] fl,
                                             input logic [31:0] tf, input bit fixed,
                                             input rsp_t want);
    script_row_t s;
    s.req = '{command: c, virt_addr: va, phys_addr: pa, page_flags: fl, table_frame: tf};
    s.fixed = fixed;
    s.want = want;
    return s;
  endfunction

  function automatic rsp_t status_rsp(input status_e st, input logic used,
                                      input logic rel, input logic [31:0] frame);
    rsp_t o;
    o = '0;
    o.status = st;
    o.table_frame_used = used;
    o.table_released = rel;
    o.released_frame = frame;
    return o;
  endfunction

  // Random request: mostly well-formed traffic on the pooled addresses, with
  // a thin layer of noise (any command, any address) on top.
  function automatic req_t draw_request();
    req_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    r.phys_addr = $urandom;
    r.page_flags = 12'($urandom);
    r.table_frame = ($urandom_range(7) == 0) ? 32'h0 : $urandom;
    r.virt_addr = {dir_pool[$urandom_range(DIR_POOL - 1)],
                   tbl_pool[$urandom_range(TBL_POOL - 1)], 12'($urandom)};
    if (pick < 5) begin
      r.command = 2'($urandom);
      r.virt_addr = $urandom;
    end else if (pick < 45) begin
      r.command = CMD_TRANSLATE;
    end else if (pick < 78) begin
      r.command = CMD_MAP;
    end else begin
      r.command = CMD_UNMAP;
    end
    return r;
  endfunction

  // Called at a falling edge. Hold start_i high until the block takes the
  // transaction, record what it owes, and return at the next falling edge.
  task automatic send_request(input req_t r, input bit fixed, input rsp_t want);
    rsp_t owed;
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    owed = walk_tables(r);
    if (fixed) owed = want;
    pending_rsp.push_back(owed);
    case (r.command)
      CMD_TRANSLATE: begin
        n_translate++;
        if (owed.phys_result != 32'h0) n_hit++;
      end
      CMD_MAP: begin
        n_map++;
        if (owed.table_frame_used) n_created++;
        if (owed.status == STAT_NO_FRAME) n_no_frame++;
        if (owed.status == STAT_PRESENT) n_present++;
      end
      CMD_UNMAP: begin
        n_unmap++;
        if (owed.table_released) n_release++;
      end
      default: n_ignored++;
    endcase
    @(negedge clk_i);
  endtask

  // Drop start_i and hold off until every owed response has come back.
  task automatic drain_responses();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending_rsp.size() != 0);
  endtask

  task automatic sender_gap(input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  task automatic compare_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  // Response checker: every done_o cycle must match the oldest owed response.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t ns: response with none owed, actual %h", $time, rsp_o);
        mismatch_count++;
      end else begin
        want = pending_rsp.pop_front();
        compare_field("phys_result", want.phys_result, rsp_o.phys_result);
        compare_field("status", 32'(want.status), 32'(rsp_o.status));
        compare_field("table_frame_used", 32'(want.table_frame_used),
                      32'(rsp_o.table_frame_used));
        compare_field("table_released", 32'(want.table_released),
                      32'(rsp_o.table_released));
        compare_field("released_frame", want.released_frame, rsp_o.released_frame);
      end
    end else if (rst_ni && done_o !== 1'b0) begin
      $display("%0t ns: done_o unknown, expected 0, actual %b", $time, done_o);
      mismatch_count++;
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t ns: timeout after %0d cycles, %0d responses still owed",
             $time, cycle_count, pending_rsp.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int unsigned idle_plan [4];
    int unsigned p, i, k;
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    cycle_count = 0;
    mismatch_count = 0;
    for (k = 0; k < DIR_ENTRIES; k++) dir_words[k] = 32'h0;
    page_words.delete();
    idle_plan = '{0, 83, 0, 9};

    // Directed transactions. Rows whose response is obvious carry it;
    // the rest are checked against the shadow tables.
    // Empty tables: translate and unmap miss, map without a frame is refused,
    // the unused command code does nothing.
    script.push_back(script_row(CMD_TRANSLATE, 32'h0000_0000, 32'h0, 12'h000,
                                32'h0, 1'b1, QUIET));
    script.push_back(script_row(CMD_UNMAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF,
                                32'hFFFF_FFFF, 1'b1, QUIET));
    script.push_back(script_row(CMD_MAP, 32'h0040_0000, 32'h1111_1000, 12'h007,
                                32'h0, 1'b1, status_rsp(STAT_NO_FRAME, 1'b0, 1'b0, 32'h0)));
    script.push_back(script_row(CMD_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF,
                                32'hFFFF_FFFF, 1'b1, QUIET));
    // Top corner of the address space with all-ones fields.
    script.push_back(script_row(CMD_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF,
                                32'hFFFF_F000, 1'b1, status_rsp(STAT_OK, 1'b1, 1'b0, 32'h0)));
    script.push_back(script_row(CMD_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 12'h000,
                                32'h0, 1'b0, QUIET));
    // Same entry again: refused, the existing table is kept.
    script.push_back(script_row(CMD_MAP, 32'hFFFF_F000, 32'h0, 12'h000, 32'h0000_2000,
                                1'b1, status_rsp(STAT_PRESENT, 1'b0, 1'b0, 32'h0)));
    // Bottom corner with all-zero fields.
    script.push_back(script_row(CMD_MAP, 32'h0000_0000, 32'h0, 12'h000, 32'h0000_1000,
                                1'b1, status_rsp(STAT_OK, 1'b1, 1'b0, 32'h0)));
    script.push_back(script_row(CMD_TRANSLATE, 32'h0000_0ABC, 32'h0, 12'h000,
                                32'h0, 1'b0, QUIET));
    script.push_back(script_row(CMD_MAP, 32'h0000_1000, 32'h1234_5678, 12'h004,
                                32'h0, 1'b0, QUIET));
    // Unmap with another entry left: table stays.
    script.push_back(script_row(CMD_UNMAP, 32'h0000_0000, 32'h0, 12'h000,
                                32'h0, 1'b0, QUIET));
    script.push_back(script_row(CMD_TRANSLATE, 32'h0000_0000, 32'h0, 12'h000,
                                32'h0, 1'b0, QUIET));
    // Last entry gone: table released.
    script.push_back(script_row(CMD_UNMAP, 32'h0000_1FFF, 32'h0, 12'h000, 32'h0,
                                1'b1, status_rsp(STAT_OK, 1'b0, 1'b1, 32'h0000_1000)));
    script.push_back(script_row(CMD_TRANSLATE, 32'h0000_1000, 32'h0, 12'h000,
                                32'h0, 1'b1, QUIET));
    // Release found only after scanning the whole table.
    script.push_back(script_row(CMD_UNMAP, 32'hFFFF_FFFF, 32'h0, 12'h000, 32'h0,
                                1'b1, status_rsp(STAT_OK, 1'b0, 1'b1, 32'hFFFF_F000)));
    // Table frame with low bits set, user bit clear in the flags.
    script.push_back(script_row(CMD_MAP, 32'h8000_0000, 32'hDEAD_B000, 12'hFFB,
                                32'hFFFF_FFFF, 1'b1, status_rsp(STAT_OK, 1'b1, 1'b0, 32'h0)));
    script.push_back(script_row(CMD_UNMAP, 32'h8000_1000, 32'h0, 12'h000,
                                32'h0, 1'b0, QUIET));
    script.push_back(script_row(CMD_TRANSLATE, 32'h8000_0FFF, 32'h0, 12'h000,
                                32'h0, 1'b0, QUIET));
    // Physical address with low bits set, flags without the present bit.
    script.push_back(script_row(CMD_MAP, 32'h8000_2123, 32'h0000_0FFF, 12'h000,
                                32'h0, 1'b0, QUIET));
    script.push_back(script_row(CMD_TRANSLATE, 32'h8000_2FFF, 32'h0, 12'h000,
                                32'h0, 1'b0, QUIET));
    script.push_back(script_row(CMD_UNMAP, 32'h8000_0000, 32'h0, 12'h000,
                                32'h0, 1'b0, QUIET));
    script.push_back(script_row(CMD_UNMAP, 32'h8000_2000, 32'h0, 12'h000, 32'h0,
                                1'b1, status_rsp(STAT_OK, 1'b0, 1'b1, 32'hFFFF_F000)));
    // Nonzero table frame whose frame bits are all zero.
    script.push_back(script_row(CMD_MAP, 32'h00C0_0000, 32'h0, 12'h004, 32'h0000_0FFF,
                                1'b1, status_rsp(STAT_OK, 1'b1, 1'b0, 32'h0)));
    script.push_back(script_row(CMD_UNMAP, 32'h00C0_0000, 32'h0, 12'h000, 32'h0,
                                1'b1, status_rsp(STAT_OK, 1'b0, 1'b1, 32'h0)));

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed table back to back; the block is still clearing its
    // directory, so the first transaction waits on busy_o.
    foreach (script[s]) send_request(script[s].req, script[s].fixed, script[s].want);
    drain_responses();

    // Random phases: each picks fresh address pools and its own idle rate.
    for (p = 0; p < 4; p++) begin
      for (k = 0; k < DIR_POOL; k++) dir_pool[k] = 10'($urandom);
      for (k = 0; k < TBL_POOL; k++)
        tbl_pool[k] = (k < TBL_POOL / 2) ? 10'($urandom_range(15)) : 10'($urandom);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) drain_responses();
        sender_gap(idle_plan[p]);
        send_request(draw_request(), 1'b0, QUIET);
      end
      drain_responses();
    end

    // Let any stray response surface before the verdict.
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Covered %0d translations (%0d hits), %0d maps (%0d tables created, %0d no frame,",
             n_translate, n_hit, n_map, n_created, n_no_frame);
    $display("  %0d already present), %0d unmaps (%0d tables released), %0d ignored commands",
             n_present, n_unmap, n_release, n_ignored);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
